### hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Shared constants and the command and status types between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int PENDING_DEPTH = 32;
	localparam int PEND_AW       = $clog2(PENDING_DEPTH);
	localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

	localparam logic [7:0] SYNC_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [5:0] TIME_INDEX = 6'h3F;
	localparam logic [5:0] RC_BYTES   = 6'd32;

	typedef struct packed {
		logic take;
		logic rd_issue;
		logic push_out;
		logic fin;
	} tfd_cmd_t;

	typedef struct packed {
		logic commit;
		logic ptr_end;
		logic rd_skip;
		logic out_free;
	} tfd_sts_t;

endpackage

### hdl/tfd_regs.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer configuration registers
// APB-style register file holding the RC block type and first RC index.
// ----------------------------------------------------------------------------
module tfd_regs
	import tfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [5:0]  rc_block_type,
	output logic [5:0]  rc_first_index
);

	localparam logic REG_RC_TYPE  = 1'b0;
	localparam logic REG_RC_FIRST = 1'b1;

	logic [5:0] rc_type_q;
	logic [5:0] rc_first_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_type_q  <= 6'd41;
			rc_first_q <= 6'd41;
		end else if (wr_en) begin
			case (paddr[2])
				REG_RC_TYPE:  rc_type_q  <= pwdata[5:0];
				REG_RC_FIRST: rc_first_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RC_TYPE:  prdata = {26'd0, rc_type_q};
			REG_RC_FIRST: prdata = {26'd0, rc_first_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign rc_block_type  = rc_type_q;
	assign rc_first_index = rc_first_q;

endmodule

### hdl/tfd_ctrl.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer controller
// Sequences byte intake and the drain of the pending store after a commit.
// ----------------------------------------------------------------------------
module tfd_ctrl
	import tfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  tfd_sts_t sts,
	output tfd_cmd_t cmd
);

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_RD  = 2'd1;
	localparam logic [1:0] ST_CHK = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	assign in_stall = (state_q != ST_RUN);

	always_comb begin
		state_nx     = state_q;
		cmd          = '0;
		case (state_q)
			ST_RUN: begin
				cmd.take = in_valid;
				if (sts.commit)
					state_nx = ST_RD;
			end
			ST_RD: begin
				if (sts.ptr_end) begin
					state_nx = ST_FIN;
				end else begin
					cmd.rd_issue = 1'b1;
					state_nx     = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.rd_skip) begin
					state_nx = ST_RD;
				end else if (sts.out_free) begin
					cmd.push_out = 1'b1;
					state_nx     = ST_RD;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin  = 1'b1;
					state_nx = ST_RUN;
				end
			end
			default: state_nx = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_nx;
	end

endmodule

### hdl/tfd_dp.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer datapath
// Byte unstuffing, frame parsing, pending field store and result register.
// ----------------------------------------------------------------------------
module tfd_dp
	import tfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tfd_cmd_t    cmd,
	output tfd_sts_t    sts,
	input  logic [7:0]  rx_byte,
	input  logic [5:0]  rc_block_type,
	input  logic [5:0]  rc_first_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  field_index,
	output logic [31:0] field_value,
	output logic        overflow,
	output logic        last
);

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_TIME = 2'd1;
	localparam logic [1:0] PH_TYPE = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	logic [1:0]       phase_q;
	logic [5:0]       bc_q;
	logic             esc_q;
	logic [31:0]      ftime_q;
	logic [5:0]       cur_type_q;
	logic [1:0]       zbc_q;
	logic [31:0]      acc_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [37:0]      mem [PENDING_DEPTH];
	logic [CNT_W-1:0] rd_ptr_q;
	logic [5:0]       rd_type_q;
	logic [31:0]      rd_val_q;
	logic [5:0]       hold_idx_q;
	logic [31:0]      hold_val_q;
	logic             out_valid_q;
	logic [5:0]       out_idx_q;
	logic [31:0]      out_val_q;
	logic             out_ovf_q;
	logic             out_last_q;

	logic [7:0]  cc;
	logic        is_sync;
	logic        is_esc;
	logic        commit;
	logic        is_rc;
	logic [5:0]  bc_nx;
	logic [31:0] acc_sh;
	logic        push_en;
	logic [5:0]  push_type;
	logic [31:0] push_val;
	logic        done_en;
	logic        out_free;

	always_comb begin
		cc        = esc_q ? (rx_byte ^ ESC_XOR) : rx_byte;
		is_sync   = (rx_byte == SYNC_BYTE);
		is_esc    = (rx_byte == ESC_BYTE);
		commit    = cmd.take && is_sync && (phase_q == PH_TYPE) && (count_q != '0);
		is_rc     = (cur_type_q == rc_block_type);
		bc_nx     = bc_q + 6'd1;
		acc_sh    = {acc_q[23:0], cc};
		push_en   = 1'b0;
		push_type = cur_type_q;
		push_val  = acc_sh;
		done_en   = 1'b0;
		if (cmd.take && !is_sync && !is_esc && (phase_q == PH_DATA)) begin
			if (is_rc) begin
				push_type = rc_first_index + {1'b0, bc_q[5:1]};
				push_val  = acc_q | {24'd0, cc};
				push_en   = bc_q[0];
				done_en   = (bc_nx >= RC_BYTES);
			end else begin
				push_en = (bc_nx >= (6'd4 - {4'd0, zbc_q}));
				done_en = push_en;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			bc_q       <= '0;
			esc_q      <= 1'b0;
			ftime_q    <= '0;
			cur_type_q <= '0;
			zbc_q      <= '0;
			acc_q      <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.fin) begin
			ftime_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.take) begin
			if (is_sync) begin
				phase_q    <= PH_TIME;
				esc_q      <= 1'b0;
				bc_q       <= '0;
				cur_type_q <= '0;
				zbc_q      <= '0;
				acc_q      <= '0;
				if (!commit) begin
					ftime_q <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else if (is_esc) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				case (phase_q)
					PH_TIME: begin
						ftime_q <= {ftime_q[23:0], cc};
						if (bc_q < 6'd3) begin
							bc_q <= bc_nx;
						end else begin
							bc_q    <= '0;
							phase_q <= PH_TYPE;
						end
					end
					PH_TYPE: begin
						cur_type_q <= cc[5:0];
						zbc_q      <= cc[7:6];
						bc_q       <= '0;
						acc_q      <= '0;
						phase_q    <= PH_DATA;
					end
					PH_DATA: begin
						if (is_rc)
							acc_q <= bc_q[0] ? push_val : {16'd0, cc, 8'd0};
						else
							acc_q <= acc_sh;
						bc_q <= bc_nx;
						if (push_en) begin
							if (count_q < CNT_W'(PENDING_DEPTH))
								count_q <= count_q + 1'b1;
							else
								ovf_q <= 1'b1;
						end
						if (done_en) begin
							cur_type_q <= '0;
							bc_q       <= '0;
							acc_q      <= '0;
							phase_q    <= PH_TYPE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en && (count_q < CNT_W'(PENDING_DEPTH)))
			mem[count_q[PEND_AW-1:0]] <= {push_type, push_val};
		if (cmd.rd_issue)
			{rd_type_q, rd_val_q} <= mem[rd_ptr_q[PEND_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rd_ptr_q   <= '0;
			hold_idx_q <= TIME_INDEX;
			hold_val_q <= ftime_q;
		end else begin
			if (cmd.rd_issue)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (cmd.push_out) begin
				hold_idx_q <= rd_type_q;
				hold_val_q <= rd_val_q;
			end
		end
		if (cmd.push_out || cmd.fin) begin
			out_idx_q  <= hold_idx_q;
			out_val_q  <= hold_val_q;
			out_ovf_q  <= ovf_q;
			out_last_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push_out || cmd.fin)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign sts.commit   = commit;
	assign sts.ptr_end  = (rd_ptr_q == count_q);
	assign sts.rd_skip  = (rd_type_q == TIME_INDEX);
	assign sts.out_free = out_free;

	assign out_valid   = out_valid_q;
	assign field_index = out_idx_q;
	assign field_value = out_val_q;
	assign overflow    = out_ovf_q;
	assign last        = out_last_q;

endmodule

### hdl/telemetry_frame_deframer.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Byte-stuffed telemetry frame parser with a pending field store.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall / rx_byte, one raw link byte per
// transaction. Output channel: out_valid / out_stall with field_index,
// field_value, overflow and last, one table update per transaction.
// Configuration: APB-style port, rc_block_type at 0x0, rc_first_index at 0x4.
// An ordinary byte produces nothing. A sync byte that commits a frame
// holding N stored fields raises in_stall while the store drains: the
// store is read one entry at a time through a registered read port, the
// timestamp comes first, and the final update carries last. A receiver
// stall lengthens the drain only while the next update waits for the
// output register to free up.
// The output register lets a byte be taken while a result still waits,
// as long as no drain is in progress.
// Reset clears the parser to wait for sync, empties the store and loads
// both configuration registers with 41; the store contents are not cleared.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer
	import tfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  field_index,
	output logic [31:0] field_value,
	output logic        overflow,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tfd_cmd_t   cmd;
	tfd_sts_t   sts;
	logic [5:0] rc_block_type;
	logic [5:0] rc_first_index;

	tfd_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.rc_block_type  (rc_block_type),
		.rc_first_index (rc_first_index)
	);

	tfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tfd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.rx_byte        (rx_byte),
		.rc_block_type  (rc_block_type),
		.rc_first_index (rc_first_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.field_index    (field_index),
		.field_value    (field_value),
		.overflow       (overflow),
		.last           (last)
	);

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |-> sts.out_free)
		else $error("result pushed into an occupied output register");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("final result pushed into an occupied output register");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.rd_issue, cmd.push_out, cmd.fin}))
		else $error("conflicting datapath commands");

	a_commit_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sts.commit |=> in_stall)
		else $error("input not held during drain");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame deframer testbench
// Feeds raw link bytes into the deframer: a short directed sequence for the
// sync, escape and discard cases, then random frames, broken frames and line
// noise under several RC block settings. A scoreboard decodes every accepted
// byte on its own and checks each table update in order. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import tfd_pkg::*;

	localparam logic [2:0] ADDR_RC_TYPE  = 3'h0;
	localparam logic [2:0] ADDR_RC_FIRST = 3'h4;
	localparam int MAX_GAP   = 18;
	localparam int SETTLE    = 24;
	localparam int CYCLE_CAP = 400000;
	localparam int ITEMS     = 470;
	localparam int PHASES    = 5;

	typedef enum logic [1:0] {SEEK_SYNC, GET_STAMP, GET_TYPE, GET_DATA} parse_t;

	typedef struct packed {
		logic [5:0]  index;
		logic [31:0] value;
		logic        ovf;
		logic        fin;
	} update_t;

	class deframe_scoreboard;
		logic [5:0]       rc_type;
		logic [5:0]       rc_first;
		parse_t           phase;
		logic [5:0]       count;
		logic             esc;
		logic [31:0]      stamp;
		logic [5:0]       cur_type;
		logic [1:0]       zeros;
		logic [31:0]      acc;
		logic [5:0]       held_type [PENDING_DEPTH];
		logic [31:0]      held_val [PENDING_DEPTH];
		logic [CNT_W-1:0] held_cnt;
		logic             held_ovf;
		update_t          updates_due [$];
		int               mismatches;

		function new();
			rc_type = 6'd41;
			rc_first = 6'd41;
			phase = SEEK_SYNC;
			count = '0;
			esc = 1'b0;
			stamp = '0;
			cur_type = '0;
			zeros = '0;
			acc = '0;
			held_cnt = '0;
			held_ovf = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] addr, logic [31:0] data);
			case (addr)
				ADDR_RC_TYPE:  rc_type = data[5:0];
				ADDR_RC_FIRST: rc_first = data[5:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return updates_due.size();
		endfunction

		function void hold_field(logic [5:0] t, logic [31:0] v);
			if (held_cnt < PENDING_DEPTH) begin
				held_type[held_cnt] = t;
				held_val[held_cnt] = v;
				held_cnt++;
			end else begin
				held_ovf = 1'b1;
			end
		endfunction

		function void field_done();
			cur_type = '0;
			count = '0;
			acc = '0;
			phase = GET_TYPE;
		endfunction

		function void emit(logic [5:0] idx, logic [31:0] v, logic fin);
			update_t u;
			u.index = idx;
			u.value = v;
			u.ovf = held_ovf;
			u.fin = fin;
			updates_due.push_back(u);
		endfunction

		function void commit_frame();
			int tail;
			int i;
			tail = -1;
			for (i = 0; i < held_cnt; i++)
				if (held_type[i] != TIME_INDEX)
					tail = i;
			emit(TIME_INDEX, stamp, tail < 0);
			for (i = 0; i < held_cnt; i++)
				if (held_type[i] != TIME_INDEX)
					emit(held_type[i], held_val[i], i == tail);
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] c;
			c = b;
			if (b == SYNC_BYTE) begin
				if (held_cnt != 0 && phase == GET_TYPE)
					commit_frame();
				phase = GET_STAMP;
				esc = 1'b0;
				count = '0;
				stamp = '0;
				cur_type = '0;
				zeros = '0;
				acc = '0;
				held_cnt = '0;
				held_ovf = 1'b0;
				return;
			end
			if (b == ESC_BYTE) begin
				esc = 1'b1;
				return;
			end
			if (esc) begin
				c = b ^ ESC_XOR;
				esc = 1'b0;
			end
			case (phase)
				GET_STAMP: begin
					stamp = {stamp[23:0], c};
					if (count < 6'd3) begin
						count++;
					end else begin
						count = '0;
						phase = GET_TYPE;
					end
				end
				GET_TYPE: begin
					cur_type = c[5:0];
					zeros = c[7:6];
					count = '0;
					acc = '0;
					phase = GET_DATA;
				end
				GET_DATA: begin
					if (cur_type == rc_type) begin
						if (!count[0]) begin
							acc = {16'h0000, c, 8'h00};
						end else begin
							acc[7:0] = c;
							hold_field(rc_first + 6'(count[5:1]), acc);
						end
						count++;
						if (count >= RC_BYTES)
							field_done();
					end else begin
						acc = {acc[23:0], c};
						count++;
						if (count >= 6'd4 - 6'(zeros)) begin
							hold_field(cur_type, acc);
							field_done();
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_update(logic [5:0] idx, logic [31:0] v, logic ovf, logic fin);
			update_t want;
			if (updates_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected update: index %0d value %h overflow %b last %b",
						idx, v, ovf, fin);
				return;
			end
			want = updates_due.pop_front();
			if (idx !== want.index || v !== want.value || ovf !== want.ovf
					|| fin !== want.fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %0d %h %b %b, got %0d %h %b %b",
						want.index, want.value, want.ovf, want.fin, idx, v, ovf, fin);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  field_index;
	logic [31:0] field_value;
	logic        overflow;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	deframe_scoreboard sb = new();
	int sent = 0;
	int cycles = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;

	telemetry_frame_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_index(field_index),
		.field_value(field_value),
		.overflow(overflow),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int hold;
		forever begin
			hold = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_update(field_index, field_value, overflow, last);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b);
		sent++;
	endtask

	task automatic push_coded(input logic [7:0] b);
		logic [7:0] flipped;
		flipped = b ^ ESC_XOR;
		if (b == SYNC_BYTE || b == ESC_BYTE || ($urandom_range(0, 15) == 0
				&& flipped != SYNC_BYTE && flipped != ESC_BYTE)) begin
			if ($urandom_range(0, 7) == 0)
				push_byte(ESC_BYTE);
			push_byte(ESC_BYTE);
			push_byte(flipped);
		end else begin
			push_byte(b);
		end
	endtask

	function automatic logic [7:0] pick_data();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return SYNC_BYTE;
			3: return ESC_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_field(input bit brief);
		logic [5:0] ty;
		logic [1:0] zc;
		int r;
		int n;
		int i;
		r = $urandom_range(0, 99);
		ty = 6'($urandom_range(0, 63));
		if (r < 20)
			ty = sb.rc_type;
		else if (r < 30)
			ty = TIME_INDEX;
		zc = 2'($urandom_range(0, 3));
		if (brief) begin
			zc = 2'd3;
			if (ty == sb.rc_type)
				ty = ty ^ 6'd1;
		end
		push_coded({zc, ty});
		n = (ty == sb.rc_type) ? int'(RC_BYTES) : 4 - int'(zc);
		for (i = 0; i < n; i++)
			push_coded(pick_data());
	endtask

	task automatic push_frame();
		int kind;
		int nf;
		int i;
		in_quiet = ($urandom_range(0, 4) == 0);
		out_quiet = ($urandom_range(0, 4) == 0);
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			nf = $urandom_range(1, 8);
			for (i = 0; i < nf; i++)
				push_byte(($urandom_range(0, 3) == 0) ? pick_data()
					: 8'($urandom_range(0, 255)));
			return;
		end
		push_byte(SYNC_BYTE);
		if (kind >= 82) begin
			nf = $urandom_range(1, 3);
			for (i = 0; i < nf; i++)
				push_coded(pick_data());
			return;
		end
		for (i = 0; i < 4; i++)
			push_coded(pick_data());
		nf = ($urandom_range(0, 99) < 8) ? $urandom_range(28, 40) : $urandom_range(0, 6);
		for (i = 0; i < nf; i++)
			push_field(nf > 20);
		if (kind >= 72) begin
			push_coded({2'($urandom_range(0, 2)), 6'($urandom_range(0, 63))});
			push_coded(pick_data());
		end
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(addr, data);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [7:0] opening [$];
		logic [5:0] type_set [PHASES];
		logic [5:0] first_set [PHASES];
		int p;
		int goal;
		opening = '{8'h00, 8'hFF, 8'h7D, 8'h7E,
			8'h7D, 8'h5E, 8'h00, 8'hFF, 8'h12,
			8'hC3, 8'h7D, 8'h7D, 8'h5D,
			8'hFF, 8'hAB,
			8'h7E, 8'h7E,
			8'h01, 8'h02, 8'h03, 8'h04,
			8'h05, 8'h11, 8'h22, 8'h7E};
		type_set = '{6'd41, 6'd0, 6'd63, 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63))};
		first_set = '{6'd41, 6'd47, 6'd0, 6'($urandom_range(0, 47)),
			6'($urandom_range(0, 47))};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			push_byte(opening[i]);
		for (p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				reg_write(ADDR_RC_TYPE, 32'(type_set[p]));
				reg_write(ADDR_RC_FIRST, 32'(first_set[p]));
			end
			goal = sent + ITEMS / PHASES;
			while (sent < goal)
				push_frame();
			push_byte(SYNC_BYTE);
		end
		settle();
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
hdl/tfd_pkg.sv
hdl/tfd_regs.sv
hdl/tfd_ctrl.sv
hdl/tfd_dp.sv
hdl/telemetry_frame_deframer.sv
sim/tb.sv
